[hdl/kmst_pkg.sv]
// kmst_pkg: shared opcodes, widths and controller/datapath interface structs
// for the keyboard matrix slot table; no dependencies
package kmst_pkg;

    localparam int SLOT_COUNT_DEF = 8;

    localparam int OP_W   = 3;
    localparam int WORD_W = 32;
    localparam int ID_W   = 16;
    localparam int LINE_W = 8;
    localparam int COL_W  = 8;
    localparam int BYTE_W = 8;

    localparam logic [OP_W-1:0] OP_PRESS       = 3'd0;
    localparam logic [OP_W-1:0] OP_RELEASE     = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE_ALL = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE_LINE  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_COLS   = 3'd4;

    // commands from the controller to the datapath
    typedef struct packed {
        logic start;   // item accepted this cycle
        logic step;    // visit the current slot and advance
        logic emit;    // load the column result into the output register
    } t_kmst_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic in_scan;   // offered item needs a slot scan
        logic last;      // current slot is the last one
        logic read_op;   // item under work is a column read
        logic out_free;  // output register can take a result this cycle
    } t_kmst_sts;

endpackage

[hdl/keyboard_matrix_slot_table.sv]
// keyboard_matrix_slot_table: top level of the emulated keyboard matrix
// instantiates kmst_ctrl and kmst_datapath; depends on kmst_pkg

// emulated keyboard matrix built on a table of SLOT_COUNT held-key slots.
// opcodes: press (0) places the bytes of the matrix word, low byte first up to
// the first zero byte, into free slots in slot order and drops what finds no
// room; release (1) frees every slot holding the host key id; release all (2)
// frees all slots; write line (3) sets the row; read columns (4) returns one
// item with the active-low column byte of the selected row (a slot whose row
// or column nibble lies outside 1..8 adds no bit). only read columns produces
// a result item. press, release and read scan the table one slot per cycle
// and stall the input until they are done, a read also loading the output
// register once any held result is no longer stalled; release all, write
// line and unused opcodes finish when accepted, with no scan. the result
// register parts the two sides, so a waiting result does not stall a new item
// until the next read is ready to deliver.
module keyboard_matrix_slot_table
    import kmst_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [WORD_W-1:0] i_matrix_word,
    input  logic [ID_W-1:0]   i_host_key_id,
    input  logic [LINE_W-1:0] i_line_select,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [COL_W-1:0]  o_column_bits
);

    t_kmst_cmd cmd;
    t_kmst_sts sts;

    // state machine: idle, slot scan, result hand-off
    kmst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // slot storage, scan index and output register
    kmst_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_opcode      (i_opcode),
        .i_matrix_word (i_matrix_word),
        .i_host_key_id (i_host_key_id),
        .i_line_select (i_line_select),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_column_bits (o_column_bits),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

endmodule

[hdl/kmst_ctrl.sv]
// kmst_ctrl: sequencing state machine for the slot table
// depends on kmst_pkg for the command and status structs
module kmst_ctrl
    import kmst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_kmst_sts i_sts,
    output t_kmst_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state     = r_state;
        o_cmd.start = 1'b0;
        o_cmd.step  = 1'b0;
        o_cmd.emit  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    if (i_sts.in_scan) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_sts.last) begin
                    n_state = i_sts.read_op ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hdl/kmst_datapath.sv]
// kmst_datapath: slot storage, scan index, row select, column accumulator
// and output register; depends on kmst_pkg
module kmst_datapath
    import kmst_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [WORD_W-1:0] i_matrix_word,
    input  logic [ID_W-1:0]   i_host_key_id,
    input  logic [LINE_W-1:0] i_line_select,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [COL_W-1:0]  o_column_bits,
    input  t_kmst_cmd         i_cmd,
    output t_kmst_sts         o_sts
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    logic [SLOT_COUNT-1:0] r_slot_valid;
    logic [BYTE_W-1:0]     r_slot_byte [SLOT_COUNT];
    logic [ID_W-1:0]       r_slot_id   [SLOT_COUNT];
    logic [LINE_W-1:0]     r_row_select;
    logic [IDX_W-1:0]      r_idx;
    logic [OP_W-1:0]       r_op;
    logic [WORD_W-1:0]     r_rest;
    logic [ID_W-1:0]       r_id;
    logic [COL_W-1:0]      r_acc;
    logic                  r_out_valid;
    logic [COL_W-1:0]      r_out_cols;

    logic              cur_valid;
    logic [BYTE_W-1:0] cur_byte;
    logic [ID_W-1:0]   cur_id;
    logic [3:0]        row_nib;
    logic [3:0]        col_nib;
    logic [3:0]        row_m1;
    logic [3:0]        col_m1;
    logic              nib_ok;
    logic              row_hit;
    logic              fill_hit;
    logic              rel_hit;
    logic [COL_W-1:0]  col_bit;

    assign cur_valid = r_slot_valid[r_idx];
    assign cur_byte  = r_slot_byte[r_idx];
    assign cur_id    = r_slot_id[r_idx];

    assign row_nib = cur_byte[7:4];
    assign col_nib = cur_byte[3:0];
    assign row_m1  = row_nib - 4'd1;
    assign col_m1  = col_nib - 4'd1;
    assign nib_ok  = (row_nib >= 4'd1) && (row_nib <= 4'd8)
                  && (col_nib >= 4'd1) && (col_nib <= 4'd8);
    assign row_hit = cur_valid && nib_ok && ({4'd0, row_m1} == r_row_select);
    assign col_bit = COL_W'(1) << col_m1[2:0];

    assign fill_hit = (r_op == OP_PRESS) && (r_rest[BYTE_W-1:0] != '0) && !cur_valid;
    assign rel_hit  = (r_op == OP_RELEASE) && cur_valid && (cur_id == r_id);

    assign o_sts.in_scan  = (i_opcode == OP_PRESS) || (i_opcode == OP_RELEASE)
                         || (i_opcode == OP_READ_COLS);
    assign o_sts.last     = (r_idx == LAST_IDX);
    assign o_sts.read_op  = (r_op == OP_READ_COLS);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_column_bits = r_out_cols;

    // control state: valid bits, row select, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_row_select <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.start && (i_opcode == OP_RELEASE_ALL)) begin
                r_slot_valid <= '0;
            end else if (i_cmd.step && fill_hit) begin
                r_slot_valid[r_idx] <= 1'b1;
            end else if (i_cmd.step && rel_hit) begin
                r_slot_valid[r_idx] <= 1'b0;
            end
            if (i_cmd.start && (i_opcode == OP_WRITE_LINE)) begin
                r_row_select <= i_line_select;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: slot contents, scan registers, accumulator, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op   <= i_opcode;
            r_rest <= i_matrix_word;
            r_id   <= i_host_key_id;
            r_idx  <= '0;
            r_acc  <= '0;
        end else if (i_cmd.step) begin
            r_idx <= o_sts.last ? '0 : r_idx + IDX_W'(1);
            if (fill_hit) begin
                r_slot_byte[r_idx] <= r_rest[BYTE_W-1:0];
                r_slot_id[r_idx]   <= r_id;
                r_rest             <= r_rest >> BYTE_W;
            end
            if (row_hit) begin
                r_acc <= r_acc | col_bit;
            end
        end
        if (i_cmd.emit) begin
            r_out_cols <= ~r_acc;
        end
    end

endmodule
